// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file spfr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define SPFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Clocked check that also runs through reset.
`define SPFR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");

`endif

// ===== hw/rtl/spfr_pkg.sv =====
`default_nettype none

package spfr_pkg;

  // Frame capture
  localparam int unsigned CAPTURE_LIMIT_DEF = 20;
  localparam int unsigned GOOD_LENGTH       = 10;
  localparam int unsigned READ_FIRST_IDX    = 3;
  localparam int unsigned READ_BYTES        = 4;
  localparam int unsigned LEN_W             = 5;

  // Configuration registers
  localparam int unsigned REG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT    = 2'd2;
  localparam logic [REG_W-1:0] REQUEST_PERIOD_RST = 16'd1000;
  localparam logic [REG_W-1:0] FIRST_TIMEOUT_RST  = 16'd500;
  localparam logic [REG_W-1:0] GAP_TIMEOUT_RST    = 16'd20;
  localparam logic [REG_W-1:0] MS_MAX             = 16'hFFFF;

  // Poll sequence
  localparam logic [1:0] POLL_LEN   = 2'd3;
  localparam logic [7:0] POLL_BYTE0 = 8'h55;
  localparam logic [7:0] POLL_BYTE1 = 8'hAA;
  localparam logic [7:0] POLL_BYTE2 = 8'h01;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX       = 2'd0,
    KIND_READING  = 2'd1,
    KIND_NO_FIRST = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       tx_byte;
    logic [31:0]      reading_hundredths;
    logic [LEN_W-1:0] frame_length;
    logic             last;
  } out_item_t;

  // Results still owed for one tick: an optional frame-end status, then poll bytes
  typedef struct packed {
    logic             end_pend;
    kind_t            end_kind;
    logic [31:0]      end_reading;
    logic [LEN_W-1:0] end_len;
    logic [1:0]       poll_left;
  } batch_t;

  // Poll byte for the given number of bytes still to send
  function automatic logic [7:0] poll_byte(input logic [1:0] left);
    logic [7:0] b;
    begin
      case (left)
        2'd3:    b = POLL_BYTE0;
        2'd2:    b = POLL_BYTE1;
        2'd1:    b = POLL_BYTE2;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spfr_emit.sv =====
`default_nettype none

module spfr_emit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               load,
  input  spfr_pkg::batch_t  batch_in,
  output logic              batch_free,
  output logic              out_valid,
  input  wire               out_stall,
  output spfr_pkg::out_item_t out_item
);

  spfr_pkg::batch_t    batch_r, batch_nxt;
  spfr_pkg::out_item_t out_item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free, pend, one_left, take;

  // Output register can take a new item when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign pend     = batch_r.end_pend || (batch_r.poll_left != 2'd0);
  assign one_left = (batch_r.end_pend && (batch_r.poll_left == 2'd0)) ||
                    (!batch_r.end_pend && (batch_r.poll_left == 2'd1));
  assign take       = out_free && pend;
  assign batch_free = !pend || (take && one_left);

  // Pick the next item: frame-end status first, then the poll bytes
  always_comb begin
    item_nxt = '0;
    if (batch_r.end_pend) begin
      item_nxt.kind               = batch_r.end_kind;
      item_nxt.reading_hundredths = batch_r.end_reading;
      item_nxt.frame_length       = batch_r.end_len;
      item_nxt.last               = (batch_r.poll_left == 2'd0);
    end else begin
      item_nxt.kind    = spfr_pkg::KIND_TX;
      item_nxt.tx_byte = spfr_pkg::poll_byte(batch_r.poll_left);
      item_nxt.last    = (batch_r.poll_left == 2'd1);
    end
  end

  // Advance the batch; a new tick replaces it
  always_comb begin
    batch_nxt = batch_r;
    if (load) begin
      batch_nxt = batch_in;
    end else if (take) begin
      if (batch_r.end_pend) begin
        batch_nxt.end_pend = 1'b0;
      end else begin
        batch_nxt.poll_left = batch_r.poll_left - 2'd1;
      end
    end
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      batch_r     <= batch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_poll_frame_receiver.sv =====
// Poll-and-receive frame engine for a serial sensor.
// Input channel (in_valid / in_stall / in_item): each item is either a
// one-millisecond tick or a received serial byte. Result channel
// (out_valid / out_stall / out_item): poll bytes to transmit, a reading,
// a no-reply timeout or a bad-length status; last marks the final result
// of one tick. Configuration (cfg_we / cfg_index / cfg_data) sets the poll
// period, first-byte timeout and inter-byte gap; write only while idle.
// A byte item is absorbed and gives no result. A tick gives zero to four
// results; the tick is first registered as a batch, and each result then
// passes into the output register, one per cycle while out_stall is low.
// The next item is taken while the final result of the previous tick
// waits in the output register. The result sequencer is the limit: one
// result a cycle when the output is not stalled.
// Reset restores the register defaults (1000, 500, 20 ms), clears the
// frame, elapsed counters and any pending results. When the receiver
// stalls, the result holds and in_stall rises once pending results back up.
`default_nettype none

module sensor_poll_frame_receiver #(
  parameter int unsigned CAPTURE_LIMIT = spfr_pkg::CAPTURE_LIMIT_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  spfr_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  wire                               out_stall,
  output spfr_pkg::out_item_t               out_item,
  input  wire                               cfg_we,
  input  wire [spfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [spfr_pkg::REG_W-1:0]         cfg_data
);

  localparam int unsigned CntW = $clog2(CAPTURE_LIMIT + 1);

  logic [spfr_pkg::REG_W-1:0] period_r, first_to_r, gap_to_r;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic [CntW+spfr_pkg::LEN_W-1:0] cnt_ext;
  logic [31:0]                reading_r, reading_nxt;
  logic                       waiting_r, waiting_nxt;
  logic [spfr_pkg::REG_W-1:0] ms_req_r, ms_req_nxt, ms_byte_r, ms_byte_nxt;
  logic [spfr_pkg::REG_W-1:0] req_inc, byte_inc;
  logic                       accept, load, batch_free;
  spfr_pkg::batch_t           batch_new;

  assign in_stall = !batch_free;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && (in_item.cmd == spfr_pkg::CMD_TICK);
  assign cnt_ext  = {{spfr_pkg::LEN_W{1'b0}}, cnt_r};

  // Saturating elapsed counters as seen by a tick
  assign req_inc  = (ms_req_r  != spfr_pkg::MS_MAX) ? ms_req_r  + 16'd1 : ms_req_r;
  assign byte_inc = (ms_byte_r != spfr_pkg::MS_MAX) ? ms_byte_r + 16'd1 : ms_byte_r;

  // Frame state update and the results a tick owes
  always_comb begin
    cnt_nxt     = cnt_r;
    reading_nxt = reading_r;
    waiting_nxt = waiting_r;
    ms_req_nxt  = ms_req_r;
    ms_byte_nxt = ms_byte_r;
    batch_new   = '0;
    if (accept) begin
      if (in_item.cmd == spfr_pkg::CMD_BYTE) begin
        if (cnt_r < CntW'(CAPTURE_LIMIT)) begin
          for (int k = 0; k < spfr_pkg::READ_BYTES; k++) begin
            if (cnt_r == CntW'(spfr_pkg::READ_FIRST_IDX + k)) begin
              reading_nxt[k*8 +: 8] = in_item.rx_byte;
            end
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        ms_byte_nxt = '0;
      end else begin
        ms_req_nxt  = req_inc;
        ms_byte_nxt = byte_inc;
        // Close the frame: no reply at all, or a gap after bytes
        if (waiting_r) begin
          if (cnt_r == '0) begin
            if (req_inc >= first_to_r) begin
              batch_new.end_pend = 1'b1;
              batch_new.end_kind = spfr_pkg::KIND_NO_FIRST;
              waiting_nxt        = 1'b0;
            end
          end else if (byte_inc >= gap_to_r) begin
            batch_new.end_pend = 1'b1;
            batch_new.end_len  = cnt_ext[spfr_pkg::LEN_W-1:0];
            if (cnt_r == CntW'(spfr_pkg::GOOD_LENGTH)) begin
              batch_new.end_kind    = spfr_pkg::KIND_READING;
              batch_new.end_reading = reading_r;
            end else begin
              batch_new.end_kind = spfr_pkg::KIND_BAD_LEN;
            end
            cnt_nxt     = '0;
            waiting_nxt = 1'b0;
          end
        end
        // Issue a new poll and restart the frame
        if (req_inc >= period_r) begin
          batch_new.poll_left = spfr_pkg::POLL_LEN;
          ms_req_nxt          = '0;
          cnt_nxt             = '0;
          reading_nxt         = '0;
          waiting_nxt         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      reading_r <= '0;
      waiting_r <= 1'b0;
      ms_req_r  <= '0;
      ms_byte_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      reading_r <= reading_nxt;
      waiting_r <= waiting_nxt;
      ms_req_r  <= ms_req_nxt;
      ms_byte_r <= ms_byte_nxt;
    end
  end

  // Configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= spfr_pkg::REQUEST_PERIOD_RST;
      first_to_r <= spfr_pkg::FIRST_TIMEOUT_RST;
      gap_to_r   <= spfr_pkg::GAP_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spfr_pkg::REG_REQUEST_PERIOD: period_r   <= cfg_data;
        spfr_pkg::REG_FIRST_TIMEOUT:  first_to_r <= cfg_data;
        spfr_pkg::REG_GAP_TIMEOUT:    gap_to_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  spfr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .batch_in   (batch_new),
    .batch_free (batch_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spfr_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module spfr_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input spfr_pkg::out_item_t out_item
);

  // Reset leaves no result pending and the input open
  `SPFR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall)

  // A taken item that is not the last one of its tick is followed at once
  `SPFR_ASSERT(a_batch_continues, out_valid && !out_stall && !out_item.last |=> out_valid)

  // The first poll byte never ends a tick's results
  `SPFR_ASSERT(a_poll_not_last, out_valid && out_item.kind == spfr_pkg::KIND_TX && out_item.tx_byte == spfr_pkg::POLL_BYTE0 |-> !out_item.last)

  // A stalled result holds
  `SPFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item))

endmodule

bind sensor_poll_frame_receiver spfr_checker u_spfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
